// ----- rtl/set_assoc_lru_cache_sim_macros.svh -----
// Assertion helpers used by the cache top module. Each expects clk_i and rst_ni in scope.
`ifndef SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SALC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/salc_pkg.sv -----
package salc_pkg;

  localparam int unsigned MAX_SET_BITS = 6;
  localparam int unsigned MAX_WAYS     = 8;

  localparam int unsigned SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_WAYS + 1);
  localparam int unsigned LINE_AW = SET_W + WAY_W;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned TAG_W   = 64;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned ENTRY_W = TAG_W + STAMP_W;

  localparam int unsigned MAX_BLOCK_BITS = 32;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS       = 2'd2;

  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [5:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;

  // Access kinds.
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;

  typedef struct packed {
    logic             clr;
    logic             en;
    logic [WAY_W-1:0] way;
    logic             vld;
  } cmp_cmd_t;

  typedef struct packed {
    logic             found;
    logic [WAY_W-1:0] hit_way;
    logic             has_inv;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] lru_way;
  } cmp_res_t;

endpackage

// ----- rtl/salc_ram.sv -----
module salc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/salc_cmp.sv -----
module salc_cmp import salc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmp_cmd_t           cmd_i,
  input  logic [TAG_W-1:0]   tag_i,
  input  logic [TAG_W-1:0]   line_tag_i,
  input  logic [STAMP_W-1:0] line_stamp_i,
  output cmp_res_t           res_o
);

  logic               found_q, found_d;
  logic               has_inv_q, has_inv_d;
  logic               first_q, first_d;
  logic [WAY_W-1:0]   hit_way_q, hit_way_d;
  logic [WAY_W-1:0]   inv_way_q, inv_way_d;
  logic [WAY_W-1:0]   lru_way_q, lru_way_d;
  logic [STAMP_W-1:0] min_stamp_q, min_stamp_d;

  always_comb begin
    found_d     = found_q;
    has_inv_d   = has_inv_q;
    first_d     = first_q;
    hit_way_d   = hit_way_q;
    inv_way_d   = inv_way_q;
    lru_way_d   = lru_way_q;
    min_stamp_d = min_stamp_q;
    if (cmd_i.clr) begin
      found_d   = 1'b0;
      has_inv_d = 1'b0;
      first_d   = 1'b1;
    end else if (cmd_i.en) begin
      // Only the lowest matching way counts as the hit.
      if (cmd_i.vld && (line_tag_i == tag_i) && !found_q) begin
        found_d   = 1'b1;
        hit_way_d = cmd_i.way;
      end
      if (!cmd_i.vld && !has_inv_q) begin
        has_inv_d = 1'b1;
        inv_way_d = cmd_i.way;
      end
      // Strict less-than keeps the lowest way on equal stamps.
      if (first_q || (line_stamp_i < min_stamp_q)) begin
        min_stamp_d = line_stamp_i;
        lru_way_d   = cmd_i.way;
      end
      first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      has_inv_q <= 1'b0;
      first_q   <= 1'b1;
    end else begin
      found_q   <= found_d;
      has_inv_q <= has_inv_d;
      first_q   <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_way_q   <= hit_way_d;
    inv_way_q   <= inv_way_d;
    lru_way_q   <= lru_way_d;
    min_stamp_q <= min_stamp_d;
  end

  assign res_o.found   = found_q;
  assign res_o.hit_way = hit_way_q;
  assign res_o.has_inv = has_inv_q;
  assign res_o.inv_way = inv_way_q;
  assign res_o.lru_way = lru_way_q;

endmodule

// ----- rtl/set_assoc_lru_cache_sim.sv -----
// Set-associative LRU cache hit/miss counter. Pulse start while busy is low to hand in one
// access; its result appears on done_o for exactly one cycle and must be taken then, as
// the block cannot be stalled. The running totals stay on their ports until the next
// access completes. For an access of a valid kind the single tag and stamp memory port
// delivers one way per cycle to a shared compare unit, walking the ways of the effective
// associativity, followed by a write-back step. A new access can be accepted in the cycle
// of the done beat. An unused kind is answered in the next cycle. After reset the block
// stays busy while it clears the valid bits one set per cycle; configuration writes are
// taken at any time.
`include "set_assoc_lru_cache_sim_macros.svh"

module set_assoc_lru_cache_sim import salc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic [ADDR_W-1:0]  address_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [5:0]         cfg_wdata_i,
  output logic               done_o,
  output logic               hit_o,
  output logic               evicted_o,
  output logic [TOTAL_W-1:0] hit_total_o,
  output logic [TOTAL_W-1:0] miss_total_o,
  output logic [TOTAL_W-1:0] evict_total_o
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_UPDATE} state_e;

  state_e             state_q, state_d;
  logic [SET_W-1:0]   clr_idx_q, clr_idx_d;
  logic [CNT_W-1:0]   rd_w_q, rd_w_d;
  logic               cmp_en_q, cmp_en_d;
  logic [WAY_W-1:0]   cmp_w_q, cmp_w_d;
  logic               mod_q, mod_d;
  logic               done_q, done_d;
  logic               hit_q, hit_d;
  logic               evicted_q, evicted_d;
  logic [STAMP_W-1:0] clock_q, clock_d;
  logic [TOTAL_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [TOTAL_W-1:0] miss_cnt_q, miss_cnt_d;
  logic [TOTAL_W-1:0] evict_cnt_q, evict_cnt_d;
  logic [2:0]         set_bits_q;
  logic [5:0]         block_bits_q;
  logic [3:0]         ways_q;

  logic [SET_W-1:0]   set_q, set_d;
  logic [TAG_W-1:0]   tag_q, tag_d;

  logic [3:0]         sb_eff;
  logic [5:0]         bb_eff;
  logic [CNT_W-1:0]   ways_eff;
  logic [6:0]         tag_shift;
  logic [SET_W-1:0]   idx_mask;
  logic [ADDR_W-1:0]  addr_shr;
  logic               accept;
  logic               issue;

  logic [WAY_W-1:0]   target;
  logic               do_evict;

  logic [MAX_WAYS-1:0] vld_row;
  logic                vld_we;
  logic [SET_W-1:0]    vld_waddr;
  logic [MAX_WAYS-1:0] vld_wdata;
  logic                line_we;
  logic [ENTRY_W-1:0]  line_rdata;

  cmp_cmd_t cmp_cmd;
  cmp_res_t cmp_res;

  // Effective configuration.
  assign sb_eff = (32'(set_bits_q) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : 4'(set_bits_q);
  assign bb_eff = (32'(block_bits_q) > MAX_BLOCK_BITS) ? 6'(MAX_BLOCK_BITS) : block_bits_q;
  always_comb begin
    if (ways_q == 4'd0) begin
      ways_eff = CNT_W'(1);
    end else if (32'(ways_q) > MAX_WAYS) begin
      ways_eff = CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = CNT_W'(ways_q);
    end
  end

  assign tag_shift = 7'(sb_eff) + 7'(bb_eff);
  assign idx_mask  = ~({SET_W{1'b1}} << sb_eff);
  assign addr_shr  = address_i >> bb_eff;
  assign set_d     = addr_shr[SET_W-1:0] & idx_mask;
  assign tag_d     = address_i >> tag_shift;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign issue  = (rd_w_q < ways_eff);

  always_comb begin
    priority if (cmp_res.found) begin
      target = cmp_res.hit_way;
    end else if (cmp_res.has_inv) begin
      target = cmp_res.inv_way;
    end else begin
      target = cmp_res.lru_way;
    end
  end
  assign do_evict = !cmp_res.found && !cmp_res.has_inv;

  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    rd_w_d      = rd_w_q;
    cmp_en_d    = 1'b0;
    cmp_w_d     = cmp_w_q;
    mod_d       = mod_q;
    done_d      = 1'b0;
    hit_d       = hit_q;
    evicted_d   = evicted_q;
    clock_d     = clock_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    line_we     = 1'b0;
    vld_we      = 1'b0;
    vld_waddr   = set_q;
    vld_wdata   = vld_row | (MAX_WAYS'(1) << target);
    cmp_cmd.clr = 1'b0;
    cmp_cmd.en  = cmp_en_q;
    cmp_cmd.way = cmp_w_q;
    cmp_cmd.vld = vld_row[cmp_w_q];
    unique case (state_q)
      ST_CLEAR: begin
        vld_we    = 1'b1;
        vld_waddr = clr_idx_q;
        vld_wdata = '0;
        clr_idx_d = clr_idx_q + SET_W'(1);
        if (clr_idx_q == {SET_W{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            KIND_LOAD, KIND_STORE, KIND_MODIFY: begin
              state_d     = ST_SCAN;
              rd_w_d      = '0;
              mod_d       = (kind_i == KIND_MODIFY);
              cmp_cmd.clr = 1'b1;
            end
            default: begin
              // An unused kind leaves the cache and the totals alone and reports the totals with hit and evicted low.
              done_d    = 1'b1;
              hit_d     = 1'b0;
              evicted_d = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_w_d   = rd_w_q + CNT_W'(1);
          cmp_en_d = 1'b1;
          cmp_w_d  = rd_w_q[WAY_W-1:0];
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        line_we     = 1'b1;
        vld_we      = 1'b1;
        clock_d     = clock_q + STAMP_W'(1);
        hit_cnt_d   = hit_cnt_q + TOTAL_W'(cmp_res.found) + TOTAL_W'(mod_q);
        miss_cnt_d  = miss_cnt_q + TOTAL_W'(!cmp_res.found);
        evict_cnt_d = evict_cnt_q + TOTAL_W'(do_evict);
        hit_d       = cmp_res.found;
        evicted_d   = do_evict;
        done_d      = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_idx_q    <= '0;
      rd_w_q       <= '0;
      cmp_en_q     <= 1'b0;
      cmp_w_q      <= '0;
      mod_q        <= 1'b0;
      done_q       <= 1'b0;
      hit_q        <= 1'b0;
      evicted_q    <= 1'b0;
      clock_q      <= '0;
      hit_cnt_q    <= '0;
      miss_cnt_q   <= '0;
      evict_cnt_q  <= '0;
      set_bits_q   <= SET_BITS_RST;
      block_bits_q <= BLOCK_BITS_RST;
      ways_q       <= WAYS_RST;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      rd_w_q      <= rd_w_d;
      cmp_en_q    <= cmp_en_d;
      cmp_w_q     <= cmp_w_d;
      mod_q       <= mod_d;
      done_q      <= done_d;
      hit_q       <= hit_d;
      evicted_q   <= evicted_d;
      clock_q     <= clock_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      evict_cnt_q <= evict_cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SET_BITS:   set_bits_q   <= cfg_wdata_i[2:0];
          CFG_BLOCK_BITS: block_bits_q <= cfg_wdata_i;
          CFG_WAYS:       ways_q       <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
  end

  // One row of valid bits per set, read while the set is being walked.
  salc_ram #(
    .WIDTH (MAX_WAYS),
    .DEPTH (2 ** SET_W)
  ) u_vld_ram (
    .clk_i   (clk_i),
    .we_i    (vld_we),
    .waddr_i (vld_waddr),
    .wdata_i (vld_wdata),
    .raddr_i (set_q),
    .rdata_o (vld_row)
  );

  // Tag and stamp of every way, one entry per set and way.
  salc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (2 ** LINE_AW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i ({set_q, target}),
    .wdata_i ({tag_q, clock_d}),
    .raddr_i ({set_q, rd_w_q[WAY_W-1:0]}),
    .rdata_o (line_rdata)
  );

  salc_cmp u_cmp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmp_cmd),
    .tag_i        (tag_q),
    .line_tag_i   (line_rdata[ENTRY_W-1:STAMP_W]),
    .line_stamp_i (line_rdata[STAMP_W-1:0]),
    .res_o        (cmp_res)
  );

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign evicted_o     = evicted_q;
  assign hit_total_o   = hit_cnt_q;
  assign miss_total_o  = miss_cnt_q;
  assign evict_total_o = evict_cnt_q;

  `SALC_ASSERT_NOW(a_done_when_idle, done_q, state_q == ST_IDLE, "done beat outside idle")
  `SALC_ASSERT_NEXT(a_accept_moves_on, accept, busy || done_q, "accepted access was dropped")
  `SALC_ASSERT_NOW(a_evict_not_hit, done_q && evicted_q, !hit_q, "eviction reported on a hit")
  `SALC_ASSERT_NOW(a_scan_in_range, state_q == ST_SCAN, rd_w_q <= ways_eff, "way walk overran")

endmodule

// ----- bench/set_assoc_lru_cache_sim_check.sv -----
module set_assoc_lru_cache_sim_check import salc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         kind_i,
  input  logic [ADDR_W-1:0]  address_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [5:0]         cfg_wdata_i,
  input  logic               done_i,
  input  logic               hit_i,
  input  logic               evicted_i,
  input  logic [TOTAL_W-1:0] hit_total_i,
  input  logic [TOTAL_W-1:0] miss_total_i,
  input  logic [TOTAL_W-1:0] evict_total_i,
  output int unsigned        mismatch_cnt_o,
  output int unsigned        open_cnt_o
);

  localparam int unsigned NUM_SETS = 1 << MAX_SET_BITS;

  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    logic [TOTAL_W-1:0] evicts;
  } outcome_t;

  logic               line_valid [NUM_SETS][MAX_WAYS];
  logic [TAG_W-1:0]   line_tag   [NUM_SETS][MAX_WAYS];
  logic [STAMP_W-1:0] line_stamp [NUM_SETS][MAX_WAYS];
  logic [STAMP_W-1:0] access_clk;
  logic [TOTAL_W-1:0] hits_q, misses_q, evicts_q;
  logic [2:0]         set_bits_q;
  logic [5:0]         block_bits_q;
  logic [3:0]         ways_q;
  outcome_t           outcome_q [$];
  int unsigned        mismatches;

  // Looks one access up in the shadow cache and updates it the way the block should.
  task automatic cache_lookup(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                              output outcome_t res);
    int unsigned        sb, bb, ways, set_idx, victim, w;
    logic [TAG_W-1:0]   tag;
    logic               found;
    logic [STAMP_W-1:0] oldest;
    res = '0;
    if (kind == KIND_LOAD || kind == KIND_STORE || kind == KIND_MODIFY) begin
      sb      = (set_bits_q > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_q;
      bb      = (block_bits_q > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : block_bits_q;
      ways    = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS) ? MAX_WAYS : ways_q);
      set_idx = 32'((addr >> bb) & ((64'd1 << sb) - 64'd1));
      tag     = addr >> (sb + bb);
      access_clk = access_clk + 1'b1;
      found  = 1'b0;
      victim = MAX_WAYS;
      for (w = 0; w < ways; w++) begin
        if (!found && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
          found  = 1'b1;
          victim = w;
        end
      end
      if (found) begin
        res.hit = 1'b1;
        hits_q  = hits_q + 1'b1;
      end else begin
        misses_q = misses_q + 1'b1;
        for (w = 0; w < ways; w++) begin
          if (victim == MAX_WAYS && !line_valid[set_idx][w]) victim = w;
        end
        if (victim == MAX_WAYS) begin
          // All ways in use are valid: the oldest stamp goes, the lowest way on a tie.
          victim = 0;
          oldest = line_stamp[set_idx][0];
          for (w = 1; w < ways; w++) begin
            if (line_stamp[set_idx][w] < oldest) begin
              oldest = line_stamp[set_idx][w];
              victim = w;
            end
          end
          res.evicted = 1'b1;
          evicts_q    = evicts_q + 1'b1;
        end
      end
      line_valid[set_idx][victim] = 1'b1;
      line_tag[set_idx][victim]   = tag;
      line_stamp[set_idx][victim] = access_clk;
      if (kind == KIND_MODIFY) hits_q = hits_q + 1'b1;
    end
    res.hits   = hits_q;
    res.misses = misses_q;
    res.evicts = evicts_q;
  endtask

  function automatic int unsigned field_diff(input string label,
                                             input logic [TOTAL_W-1:0] want,
                                             input logic [TOTAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t    want, got;
    int unsigned s, w;
    if (!rst_ni) begin
      for (s = 0; s < NUM_SETS; s++) begin
        for (w = 0; w < MAX_WAYS; w++) line_valid[s][w] = 1'b0;
      end
      access_clk     = '0;
      hits_q         = '0;
      misses_q       = '0;
      evicts_q       = '0;
      set_bits_q     = SET_BITS_RST;
      block_bits_q   = BLOCK_BITS_RST;
      ways_q         = WAYS_RST;
      mismatches     = 0;
      outcome_q.delete();
      mismatch_cnt_o <= 0;
      open_cnt_o     <= 0;
    end else begin
      if (done_i) begin
        got = '{hit_i, evicted_i, hit_total_i, miss_total_i, evict_total_i};
        if (outcome_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with no access outstanding, expected none, got %h",
                   $time, got);
        end else begin
          want = outcome_q.pop_front();
          mismatches += field_diff("hit", TOTAL_W'(want.hit), TOTAL_W'(got.hit));
          mismatches += field_diff("evicted", TOTAL_W'(want.evicted), TOTAL_W'(got.evicted));
          mismatches += field_diff("hit_total", want.hits, got.hits);
          mismatches += field_diff("miss_total", want.misses, got.misses);
          mismatches += field_diff("evict_total", want.evicts, got.evicts);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SET_BITS:   set_bits_q = cfg_wdata_i[2:0];
          CFG_BLOCK_BITS: block_bits_q = cfg_wdata_i;
          CFG_WAYS:       ways_q = cfg_wdata_i[3:0];
          default:        ;
        endcase
      end
      if (start_i && !busy_i) begin
        cache_lookup(kind_i, address_i, want);
        outcome_q.push_back(want);
      end
      mismatch_cnt_o <= mismatches;
      open_cnt_o     <= outcome_q.size();
    end
  end

endmodule

// ----- bench/set_assoc_lru_cache_sim_test.sv -----
module set_assoc_lru_cache_sim_test;
  import salc_pkg::*;

  localparam logic [1:0] KIND_NONE   = 2'd3;
  localparam logic [1:0] CFG_SPARE   = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 150000;
  localparam int unsigned TAIL_CYCLES = MAX_WAYS + 8;
  localparam int unsigned POOL_MAX    = 40;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         acc_kind = KIND_LOAD;
  logic [ADDR_W-1:0]  acc_addr = '0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_idx = CFG_SET_BITS;
  logic [5:0]         cfg_wdata = '0;
  logic               done;
  logic               hit;
  logic               evicted;
  logic [TOTAL_W-1:0] hit_total, miss_total, evict_total;
  int unsigned        mismatch_cnt, open_cnt;
  int unsigned        cycle_cnt = 0;
  int unsigned        offset_bits = BLOCK_BITS_RST;
  logic [ADDR_W-1:0]  hot_pool [POOL_MAX];

  always #5 clk_i = ~clk_i;

  set_assoc_lru_cache_sim dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (acc_kind),
    .address_i     (acc_addr),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .done_o        (done),
    .hit_o         (hit),
    .evicted_o     (evicted),
    .hit_total_o   (hit_total),
    .miss_total_o  (miss_total),
    .evict_total_o (evict_total)
  );

  set_assoc_lru_cache_sim_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .kind_i         (acc_kind),
    .address_i      (acc_addr),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .done_i         (done),
    .hit_i          (hit),
    .evicted_i      (evicted),
    .hit_total_i    (hit_total),
    .miss_total_i   (miss_total),
    .evict_total_i  (evict_total),
    .mismatch_cnt_o (mismatch_cnt),
    .open_cnt_o     (open_cnt)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL set_assoc_lru_cache_sim");
      $finish;
    end
  end

  // Holds one access on the inputs until the block takes it.
  task automatic issue(input logic [1:0] kind, input logic [ADDR_W-1:0] addr);
    start    <= 1'b1;
    acc_kind <= kind;
    acc_addr <= addr;
    do @(posedge clk_i); while (busy);
  endtask

  // Keeps start low with junk on the access lines; n sets how long and is at least one.
  task automatic pause(input int unsigned n);
    start    <= 1'b0;
    acc_kind <= 2'($urandom);
    acc_addr <= {$urandom, $urandom};
    repeat (n) @(posedge clk_i);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (open_cnt != 0) @(posedge clk_i);
  endtask

  task automatic program_geometry(input logic [5:0] set_raw, input logic [5:0] block_raw,
                                  input logic [5:0] ways_raw, input bit poke_spare);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SET_BITS;
    cfg_wdata <= set_raw;
    @(posedge clk_i);
    cfg_idx   <= CFG_BLOCK_BITS;
    cfg_wdata <= block_raw;
    @(posedge clk_i);
    cfg_idx   <= CFG_WAYS;
    cfg_wdata <= ways_raw;
    @(posedge clk_i);
    if (poke_spare) begin
      cfg_idx   <= CFG_SPARE;
      cfg_wdata <= 6'($urandom);
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
    offset_bits = (block_raw > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : block_raw;
  endtask

  initial begin
    logic [ADDR_W-1:0] addr;
    logic [1:0]        kind;
    int unsigned       phase, n, burst_left, pool_len, pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: 16 sets, 16-byte blocks, direct mapped.
    issue(KIND_LOAD, 64'h0);
    issue(KIND_LOAD, 64'h8);
    issue(KIND_STORE, 64'h0);
    issue(KIND_MODIFY, 64'h4);
    issue(KIND_NONE, '1);
    issue(KIND_STORE, '1);
    // Same set, tag equal to the low 32 bits of the previous tag: must miss.
    issue(KIND_LOAD, 64'h0000_00FF_FFFF_FFFF);
    issue(KIND_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(KIND_LOAD, 64'h5555_5555_5555_5555);
    issue(KIND_LOAD, 64'h8000_0000_0000_0000);
    settle();

    // Out-of-range values clamp: set bits to the maximum, block bits to 32, zero ways to one.
    program_geometry(6'h3F, 6'h3F, 6'h30, 1'b1);
    issue(KIND_LOAD, 64'hFFFF_FFFF_0000_0000);
    issue(KIND_STORE, 64'h0000_0001_0000_0000);
    settle();

    // One set, byte blocks, eight ways: fill, then the oldest line is replaced.
    program_geometry(6'd0, 6'd0, 6'hF, 1'b0);
    for (n = 1; n <= 9; n++) issue(KIND_LOAD, 64'(n));
    issue(KIND_LOAD, 64'd2);
    settle();
    // Shrinking hides the upper ways; growing again makes them visible.
    program_geometry(6'd0, 6'd0, 6'd2, 1'b0);
    issue(KIND_LOAD, 64'd8);
    settle();
    program_geometry(6'd0, 6'd0, 6'd8, 1'b0);
    issue(KIND_LOAD, 64'd7);

    for (phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0:       program_geometry(6'd0, 6'd0, 6'd1, 1'b0);
        1:       program_geometry(6'd6, 6'd32, 6'd8, 1'b0);
        2:       program_geometry(6'd6, 6'd0, 6'd3, 1'b0);
        default: program_geometry(6'($urandom), 6'($urandom), 6'($urandom),
                                  1'($urandom_range(0, 1)));
      endcase
      pool_len = $urandom_range(2, POOL_MAX);
      for (n = 0; n < pool_len; n++) hot_pool[n] = {$urandom, $urandom};
      burst_left = 0;
      for (n = 0; n < 82; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 9));
        end
        burst_left--;
        pick = $urandom_range(0, 99);
        kind = (pick < 5) ? KIND_NONE : 2'($urandom_range(0, 2));
        if (pick < 15) begin
          addr = {$urandom, $urandom};
        end else begin
          // Reuse a hot line with a random byte offset inside its block.
          addr = hot_pool[$urandom_range(0, pool_len - 1)] ^
                 ({$urandom, $urandom} & ((64'd1 << offset_bits) - 64'd1));
        end
        issue(kind, addr);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && open_cnt == 0) begin
      $display("PASS set_assoc_lru_cache_sim");
    end else begin
      $display("FAIL set_assoc_lru_cache_sim");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/salc_pkg.sv
rtl/salc_ram.sv
rtl/salc_cmp.sv
rtl/set_assoc_lru_cache_sim.sv
bench/set_assoc_lru_cache_sim_check.sv
bench/set_assoc_lru_cache_sim_test.sv
